// File: src/sbus_frame_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// S.BUS frame decoder - assertion macros
// Shared concurrent assertion forms, sampled on clk and idle while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_CORE_DEFINES_SVH
`define SBUS_FRAME_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define SBF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/sbf_pkg.sv
// ----------------------------------------------------------------------------
// S.BUS frame decoder - package
// Shared constants, register codes and transfer types.
// ----------------------------------------------------------------------------
`default_nettype none

package sbf_pkg;

	localparam int DEF_FRAME_BYTES = 25;
	localparam int NUM_ANALOG      = 16;
	localparam int NUM_CHANNELS    = 18;
	localparam int CH_W            = 11;
	localparam int CH_IDX_W        = 5;
	localparam int DATA_FIRST      = 1;
	localparam int DATA_LAST       = 22;
	localparam int CNT_W           = 32;

	localparam logic [CH_W-1:0] DIGITAL_ON = 11'h7FF;

	localparam logic [1:0] MODE_FAILSAFE = 2'd0;
	localparam logic [1:0] MODE_LOW      = 2'd1;
	localparam logic [1:0] MODE_HIGH     = 2'd2;
	localparam logic [1:0] MODE_IDLE     = 2'd3;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_CHANNEL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_POSITION  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE_TOLERANCE = 3'd4;

	localparam logic [7:0]          RST_START_MARKER     = 8'd15;
	localparam logic [7:0]          RST_END_MARKER       = 8'd0;
	localparam logic [4:0]          RST_MODE_CHANNEL     = 5'd4;
	localparam logic [CH_W-1:0]     RST_MIDDLE_POSITION  = 11'd1024;
	localparam logic [CH_W-1:0]     RST_MIDDLE_TOLERANCE = 11'd100;

	typedef struct packed {
		logic [7:0]      start_marker;
		logic [7:0]      end_marker;
		logic [4:0]      mode_channel;
		logic [CH_W-1:0] middle_position;
		logic [CH_W-1:0] middle_tolerance;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic                frame_ok;
		logic [CH_IDX_W-1:0] channel_index;
		logic [CH_W-1:0]     channel_value;
		logic                failsafe;
		logic [1:0]          switch_mode;
		logic [CNT_W-1:0]    good_frames;
		logic [CNT_W-1:0]    error_frames;
		logic                last;
	} res_item_t;

	typedef struct packed {
		logic             start;
		logic             ok;
		logic             bank;
		logic             fs;
		logic [1:0]       dig;
		logic [CNT_W-1:0] good;
		logic [CNT_W-1:0] err;
	} job_t;

endpackage

`default_nettype wire

// File: src/sbf_stream_if.sv
// ----------------------------------------------------------------------------
// S.BUS frame decoder - stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbf_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: src/sbf_store.sv
// ----------------------------------------------------------------------------
// S.BUS frame decoder - frame store
// Two-bank byte memory, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_store import sbf_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [$clog2(2*(FRAME_BYTES-1))-1:0]     waddr,
	input  wire logic [7:0]                               wdata,
	input  wire logic                                     re,
	input  wire logic [$clog2(2*(FRAME_BYTES-1))-1:0]     raddr,
	output logic      [7:0]                               rdata
);

	localparam int DEPTH = 2 * (FRAME_BYTES - 1);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/sbf_collect.sv
// ----------------------------------------------------------------------------
// S.BUS frame decoder - byte collector
// Writes frame bytes to the store, checks frame markers, keeps the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sbf_collect import sbf_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	sbf_stream_if.sink                                    rx,
	input  wire cfg_t                                     cfg,
	input  wire logic                                     busy,
	output job_t                                          job,
	output logic                                          we,
	output logic      [$clog2(2*(FRAME_BYTES-1))-1:0]     waddr,
	output logic      [7:0]                               wdata
);

	localparam int STORE_DEPTH = FRAME_BYTES - 1;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int ADDR_W      = $clog2(2 * STORE_DEPTH);
	localparam int FLAG_POS    = FRAME_BYTES - 2;

	logic [POS_W-1:0] pos_q;
	logic             bank_q;
	logic [7:0]       byte0_q;
	logic [7:0]       flag_q;
	logic [CNT_W-1:0] good_q;
	logic [CNT_W-1:0] err_q;
	job_t             job_q;

	logic at_end;
	logic xfer;
	logic ok;

	assign at_end   = pos_q == POS_W'(STORE_DEPTH);
	assign rx.ready = !(at_end && (busy || job_q.start));
	assign xfer     = rx.valid && rx.ready;
	assign ok       = (byte0_q == cfg.start_marker) && (rx.payload.rx_byte == cfg.end_marker);

	assign we    = xfer && !at_end;
	assign waddr = ADDR_W'(pos_q) + (bank_q ? ADDR_W'(STORE_DEPTH) : ADDR_W'(0));
	assign wdata = rx.payload.rx_byte;
	assign job   = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			bank_q <= 1'b0;
			good_q <= '0;
			err_q  <= '0;
			job_q  <= '0;
		end else begin
			job_q.start <= xfer && at_end;
			if (xfer) begin
				if (at_end) begin
					pos_q       <= '0;
					job_q.ok    <= ok;
					job_q.bank  <= bank_q;
					job_q.fs    <= flag_q[3];
					job_q.dig   <= flag_q[1:0];
					job_q.good  <= ok ? good_q + 1'b1 : good_q;
					job_q.err   <= ok ? err_q : err_q + 1'b1;
					if (ok) begin
						good_q <= good_q + 1'b1;
						bank_q <= !bank_q;
					end else begin
						err_q <= err_q + 1'b1;
					end
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && pos_q == '0) begin
			byte0_q <= rx.payload.rx_byte;
		end
		if (xfer && pos_q == POS_W'(FLAG_POS)) begin
			flag_q <= rx.payload.rx_byte;
		end
	end

endmodule

`default_nettype wire

// File: src/sbf_unpack.sv
// ----------------------------------------------------------------------------
// S.BUS frame decoder - channel unpacker
// Reads a stored frame, works out the switch mode and streams 18 results, or one rejection for a bad frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sbus_frame_decoder_core_defines.svh"

module sbf_unpack import sbf_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire job_t                                     job,
	input  wire cfg_t                                     cfg,
	output logic                                          busy,
	output logic                                          re,
	output logic      [$clog2(2*(FRAME_BYTES-1))-1:0]     raddr,
	input  wire logic [7:0]                               rdata,
	sbf_stream_if.source                                  res
);

	localparam int STORE_DEPTH = FRAME_BYTES - 1;
	localparam int ADDR_W      = $clog2(2 * STORE_DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MRD    = 3'd1;
	localparam logic [2:0] ST_MCALC  = 3'd2;
	localparam logic [2:0] ST_STREAM = 3'd3;
	localparam logic [2:0] ST_DIG    = 3'd4;
	localparam logic [2:0] ST_ERR    = 3'd5;

	logic [2:0]          st_q;
	logic [4:0]          mch_q;
	logic [4:0]          mbyte_q;
	logic [2:0]          msh_q;
	logic [1:0]          rcnt_q;
	logic                pend_q;
	logic [23:0]         w_q;
	logic [1:0]          mode_q;
	logic [17:0]         acc_q;
	logic [4:0]          cnt_q;
	logic [4:0]          sbyte_q;
	logic [CH_IDX_W-1:0] ch_q;
	logic                bank_q;
	logic                fs_q;
	logic [1:0]          dig_q;
	logic [CNT_W-1:0]    good_q;
	logic [CNT_W-1:0]    err_q;
	logic                out_valid_q;
	res_item_t           out_q;

	logic                out_free;
	logic [7:0]          mbit;
	logic [17:0]         acc_in;
	logic [4:0]          cnt_in;
	logic                emit;
	logic [17:0]         acc_nx;
	logic [4:0]          cnt_nx;
	logic                issue;
	logic [4:0]          rd_idx;
	logic [23:0]         w_sh;
	logic [CH_W-1:0]     sw;
	logic signed [12:0]  lo;
	logic [11:0]         hi;
	logic                below;
	logic                above;
	logic [1:0]          mode_nx;
	logic                ld;
	res_item_t           ld_item;

	assign out_free    = !out_valid_q || res.ready;
	assign res.valid   = out_valid_q;
	assign res.payload = out_q;
	assign busy        = st_q != ST_IDLE;

	assign mbit = 8'(cfg.mode_channel[3:0]) * 8'd11;

	assign acc_in = pend_q ? (acc_q | (18'(rdata) << cnt_q)) : acc_q;
	assign cnt_in = pend_q ? cnt_q + 5'd8 : cnt_q;
	assign emit   = (st_q == ST_STREAM) && (cnt_in >= 5'(CH_W)) && out_free;
	assign acc_nx = emit ? acc_in >> CH_W : acc_in;
	assign cnt_nx = emit ? cnt_in - 5'(CH_W) : cnt_in;
	assign issue  = (st_q == ST_STREAM) && (cnt_nx <= 5'(CH_W - 1))
		&& (sbyte_q <= 5'(DATA_LAST));

	always_comb begin
		re     = 1'b0;
		rd_idx = sbyte_q;
		if (st_q == ST_MRD) begin
			re     = rcnt_q != 2'd3;
			rd_idx = mbyte_q + 5'(rcnt_q);
		end else if (issue) begin
			re = 1'b1;
		end
	end

	assign raddr = ADDR_W'(rd_idx) + (bank_q ? ADDR_W'(STORE_DEPTH) : ADDR_W'(0));

	assign w_sh = w_q >> msh_q;

	always_comb begin
		if (mch_q < 5'(NUM_ANALOG)) begin
			sw = w_sh[CH_W-1:0];
		end else if (mch_q == 5'(NUM_ANALOG)) begin
			sw = dig_q[0] ? DIGITAL_ON : '0;
		end else if (mch_q == 5'(NUM_ANALOG + 1)) begin
			sw = dig_q[1] ? DIGITAL_ON : '0;
		end else begin
			sw = '0;
		end
	end

	assign lo    = $signed({2'b00, cfg.middle_position}) - $signed({2'b00, cfg.middle_tolerance});
	assign hi    = {1'b0, cfg.middle_position} + {1'b0, cfg.middle_tolerance};
	assign below = $signed({2'b00, sw}) < lo;
	assign above = {1'b0, sw} > hi;

	always_comb begin
		if (fs_q) begin
			mode_nx = MODE_FAILSAFE;
		end else if (below) begin
			mode_nx = MODE_LOW;
		end else if (above) begin
			mode_nx = MODE_HIGH;
		end else begin
			mode_nx = MODE_IDLE;
		end
	end

	always_comb begin
		ld                    = 1'b0;
		ld_item.frame_ok      = 1'b1;
		ld_item.channel_index = ch_q;
		ld_item.channel_value = acc_in[CH_W-1:0];
		ld_item.failsafe      = fs_q;
		ld_item.switch_mode   = mode_q;
		ld_item.good_frames   = good_q;
		ld_item.error_frames  = err_q;
		ld_item.last          = 1'b0;
		case (st_q)
			ST_STREAM: begin
				ld = emit;
			end
			ST_DIG: begin
				ld                    = out_free;
				ld_item.channel_value = dig_q[ch_q == 5'(NUM_CHANNELS - 1)] ? DIGITAL_ON : '0;
				ld_item.last          = ch_q == 5'(NUM_CHANNELS - 1);
			end
			ST_ERR: begin
				ld                    = out_free;
				ld_item.frame_ok      = 1'b0;
				ld_item.channel_index = '0;
				ld_item.channel_value = '0;
				ld_item.failsafe      = 1'b0;
				ld_item.switch_mode   = MODE_FAILSAFE;
				ld_item.last          = 1'b1;
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rcnt_q      <= '0;
			pend_q      <= 1'b0;
			cnt_q       <= '0;
			sbyte_q     <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (job.start) begin
						rcnt_q <= '0;
						pend_q <= 1'b0;
						if (!job.ok) begin
							st_q <= ST_ERR;
						end else if (cfg.mode_channel < 5'(NUM_ANALOG)) begin
							st_q <= ST_MRD;
						end else begin
							st_q <= ST_MCALC;
						end
					end
				end
				ST_MRD: begin
					pend_q <= re;
					if (re) begin
						rcnt_q <= rcnt_q + 1'b1;
					end
					if (pend_q && rcnt_q == 2'd3) begin
						st_q <= ST_MCALC;
					end
				end
				ST_MCALC: begin
					pend_q  <= 1'b0;
					cnt_q   <= '0;
					sbyte_q <= 5'(DATA_FIRST);
					ch_q    <= '0;
					st_q    <= ST_STREAM;
				end
				ST_STREAM: begin
					cnt_q  <= cnt_nx;
					pend_q <= issue;
					if (issue) begin
						sbyte_q <= sbyte_q + 1'b1;
					end
					if (emit) begin
						ch_q <= ch_q + 1'b1;
						if (ch_q == 5'(NUM_ANALOG - 1)) begin
							st_q <= ST_DIG;
						end
					end
				end
				ST_DIG: begin
					if (out_free) begin
						ch_q <= ch_q + 1'b1;
						if (ch_q == 5'(NUM_CHANNELS - 1)) begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_q <= ld_item;
		end
		if (st_q == ST_IDLE && job.start) begin
			bank_q  <= job.bank;
			fs_q    <= job.fs;
			dig_q   <= job.dig;
			good_q  <= job.good;
			err_q   <= job.err;
			mch_q   <= cfg.mode_channel;
			mbyte_q <= 5'(mbit >> 3) + 5'(DATA_FIRST);
			msh_q   <= mbit[2:0];
		end
		if (st_q == ST_MRD && pend_q) begin
			w_q <= {rdata, w_q[23:8]};
		end
		if (st_q == ST_MCALC) begin
			mode_q <= mode_nx;
			acc_q  <= '0;
		end else if (st_q == ST_STREAM) begin
			acc_q <= acc_nx;
		end
	end

	`SBF_ASSERT_IMP(a_acc_room, pend_q && st_q == ST_STREAM, cnt_q <= 5'(CH_W - 1),
		"accumulator would overflow on byte arrival")
	`SBF_ASSERT_IMP(a_job_idle, job.start, st_q == ST_IDLE,
		"frame job issued while unpacker busy")
	`SBF_ASSERT_NXT(a_last_idle, ld && ld_item.last, st_q == ST_IDLE,
		"unpacker not idle after final result")
	`SBF_ASSERT_IMP(a_dig_index, st_q == ST_DIG,
		ch_q == 5'(NUM_ANALOG) || ch_q == 5'(NUM_CHANNELS - 1),
		"digital channel index out of place")

endmodule

`default_nettype wire

// File: src/sbus_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// S.BUS frame decoder - top level
// Collects 25-byte S.BUS frames and emits decoded channel results.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle unless a closing byte is held. Bytes 0 to
// 23 of a frame go into a two-bank frame memory, so the next frame fills one bank
// while the previous one is read from the other. On the closing byte the start
// and end markers are checked: a bad frame gives a single rejected result, a good
// frame gives 18 channel results, at most one per cycle as the output is taken.
// Unpacking a good frame reads 3 bytes for an analog mode channel, then 22 data
// bytes through the single memory read port; if the next frame closes before
// that is done, its closing byte waits. The output register lets bytes keep
// flowing while a result waits to be taken. Configuration registers are written
// through cfg_we, cfg_idx and cfg_data; writes to unknown indexes are dropped.
`default_nettype none

module sbus_frame_decoder_core import sbf_pkg::*; #(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	sbf_stream_if.sink                 rx,
	sbf_stream_if.source               res,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = $clog2(2 * (FRAME_BYTES - 1));

	cfg_t              cfg_q;
	job_t              job;
	logic              busy;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker     <= RST_START_MARKER;
			cfg_q.end_marker       <= RST_END_MARKER;
			cfg_q.mode_channel     <= RST_MODE_CHANNEL;
			cfg_q.middle_position  <= RST_MIDDLE_POSITION;
			cfg_q.middle_tolerance <= RST_MIDDLE_TOLERANCE;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_START_MARKER:     cfg_q.start_marker     <= cfg_data[7:0];
				CFG_END_MARKER:       cfg_q.end_marker       <= cfg_data[7:0];
				CFG_MODE_CHANNEL:     cfg_q.mode_channel     <= cfg_data[4:0];
				CFG_MIDDLE_POSITION:  cfg_q.middle_position  <= cfg_data[CH_W-1:0];
				CFG_MIDDLE_TOLERANCE: cfg_q.middle_tolerance <= cfg_data[CH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	sbf_collect #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_collect (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.cfg    (cfg_q),
		.busy   (busy),
		.job    (job),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	sbf_store #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	sbf_unpack #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_unpack (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.cfg    (cfg_q),
		.busy   (busy),
		.re     (re),
		.raddr  (raddr),
		.rdata  (rdata),
		.res    (res)
	);

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// S.BUS frame decoder - testbench
// Streams 25-byte frames (well-formed, broken and stray bytes) into the decoder
// under random valid/ready throttling and register settings. Every channel
// result and every rejection is predicted and checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sbf_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 48;
	localparam int LONG_HOLD     = 300;
	localparam int TIMEOUT_NS    = 2_000_000;
	localparam int MAX_REPORTS   = 40;
	localparam int FRAME_DATA    = DATA_LAST - DATA_FIRST + 1;
	localparam int FRAME_STORE   = DEF_FRAME_BYTES - 1;
	localparam int FLAG_BYTE     = DATA_LAST + 1;
	localparam int FLAG_DIG0     = 0;
	localparam int FLAG_DIG1     = 1;
	localparam int FLAG_FS       = 3;
	localparam int CH_MAX        = 2047;

	typedef logic [CH_W-1:0] analog_t [NUM_ANALOG];

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sbf_stream_if #(.payload_t(rx_item_t))  rx_ch ();
	sbf_stream_if #(.payload_t(res_item_t)) res_ch ();

	sbus_frame_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx_ch),
		.res      (res_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	cfg_t ctrl = '{
		start_marker:     RST_START_MARKER,
		end_marker:       RST_END_MARKER,
		mode_channel:     RST_MODE_CHANNEL,
		middle_position:  RST_MIDDLE_POSITION,
		middle_tolerance: RST_MIDDLE_TOLERANCE
	};

	logic [7:0]       frame_buf [FRAME_STORE];
	int unsigned      frame_fill  = 0;
	logic [CNT_W-1:0] good_tally  = '0;
	logic [CNT_W-1:0] error_tally = '0;
	res_item_t        decoded_q [$];

	int unsigned mismatches    = 0;
	int unsigned src_idle_pct  = 29;
	int unsigned sink_idle_pct = 54;
	int unsigned stall_asks    = 0;
	int unsigned stall_taken   = 0;
	int unsigned stall_left    = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void collect_byte(input logic [7:0] b);
		logic [8*FRAME_DATA-1:0] bits;
		logic [CH_W-1:0]         chans [NUM_CHANNELS];
		logic [7:0]              flags;
		logic [CH_W-1:0]         sw;
		logic [1:0]              mode;
		int                      lo;
		int                      hi;
		int                      i;
		res_item_t               r;

		if (frame_fill < FRAME_STORE) begin
			frame_buf[frame_fill] = b;
			frame_fill++;
			return;
		end
		frame_fill = 0;
		if (frame_buf[0] != ctrl.start_marker || b != ctrl.end_marker) begin
			error_tally++;
			r = '{frame_ok: 1'b0, channel_index: '0, channel_value: '0, failsafe: 1'b0,
				switch_mode: MODE_FAILSAFE, good_frames: good_tally,
				error_frames: error_tally, last: 1'b1};
			decoded_q = {decoded_q, r};
			return;
		end
		good_tally++;
		for (i = 0; i < FRAME_DATA; i++)
			bits[8*i +: 8] = frame_buf[DATA_FIRST + i];
		for (i = 0; i < NUM_ANALOG; i++)
			chans[i] = bits[CH_W*i +: CH_W];
		flags = frame_buf[FLAG_BYTE];
		chans[NUM_ANALOG]     = flags[FLAG_DIG0] ? DIGITAL_ON : '0;
		chans[NUM_ANALOG + 1] = flags[FLAG_DIG1] ? DIGITAL_ON : '0;
		sw = (ctrl.mode_channel < NUM_CHANNELS) ? chans[ctrl.mode_channel] : '0;
		lo = int'(ctrl.middle_position) - int'(ctrl.middle_tolerance);
		hi = int'(ctrl.middle_position) + int'(ctrl.middle_tolerance);
		if (flags[FLAG_FS])
			mode = MODE_FAILSAFE;
		else if (int'(sw) < lo)
			mode = MODE_LOW;
		else if (int'(sw) > hi)
			mode = MODE_HIGH;
		else
			mode = MODE_IDLE;
		for (i = 0; i < NUM_CHANNELS; i++) begin
			r = '{frame_ok: 1'b1, channel_index: CH_IDX_W'(i), channel_value: chans[i],
				failsafe: flags[FLAG_FS], switch_mode: mode, good_frames: good_tally,
				error_frames: error_tally, last: (i == NUM_CHANNELS - 1)};
			decoded_q = {decoded_q, r};
		end
	endfunction

	function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
			input logic [CNT_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : res_check
		res_item_t got;
		res_item_t want;

		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.payload;
			if (decoded_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected transfer expected none actual index %0d",
						$time, got.channel_index);
			end else begin
				want = decoded_q.pop_front();
				check_field("frame_ok", want.frame_ok, got.frame_ok);
				check_field("channel_index", want.channel_index, got.channel_index);
				check_field("channel_value", want.channel_value, got.channel_value);
				check_field("failsafe", want.failsafe, got.failsafe);
				check_field("switch_mode", want.switch_mode, got.switch_mode);
				check_field("good_frames", want.good_frames, got.good_frames);
				check_field("error_frames", want.error_frames, got.error_frames);
				check_field("last", want.last, got.last);
			end
		end
	end

	always @(posedge clk) begin : res_throttle
		if (stall_asks != stall_taken) begin
			stall_taken = stall_asks;
			stall_left  = LONG_HOLD;
		end
		if (stall_left != 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.payload <= '{rx_byte: b};
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		collect_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] first, input analog_t ch,
			input logic [7:0] flags, input logic [7:0] closing);
		logic [8*FRAME_DATA-1:0] bits;
		int                      i;

		bits = '0;
		for (i = 0; i < NUM_ANALOG; i++)
			bits[CH_W*i +: CH_W] = ch[i];
		send_byte(first);
		for (i = 0; i < FRAME_DATA; i++)
			send_byte(bits[8*i +: 8]);
		send_byte(flags);
		send_byte(closing);
	endtask

	// complete any partial frame with stray bytes
	task automatic realign();
		while (frame_fill != 0)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic settle();
		realign();
		rx_ch.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_START_MARKER:     ctrl.start_marker     = data[7:0];
			CFG_END_MARKER:       ctrl.end_marker       = data[7:0];
			CFG_MODE_CHANNEL:     ctrl.mode_channel     = data[4:0];
			CFG_MIDDLE_POSITION:  ctrl.middle_position  = data;
			CFG_MIDDLE_TOLERANCE: ctrl.middle_tolerance = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic random_analog(output analog_t ch);
		int i;

		for (i = 0; i < NUM_ANALOG; i++) begin
			case ($urandom_range(7))
				0:       ch[i] = '0;
				1:       ch[i] = DIGITAL_ON;
				default: ch[i] = CH_W'($urandom_range(CH_MAX));
			endcase
		end
	endtask

	task automatic test_default_setup();
		analog_t ch;

		ch = '{default: '0};
		send_frame(ctrl.start_marker, ch, 8'h00, ctrl.end_marker);
		ch = '{default: DIGITAL_ON};
		send_frame(ctrl.start_marker, ch, 8'h03, ctrl.end_marker);
		ch = '{default: 11'h2AA};
		ch[ctrl.mode_channel] = ctrl.middle_position - ctrl.middle_tolerance;
		send_frame(ctrl.start_marker, ch, 8'hF4, ctrl.end_marker);
		ch[ctrl.mode_channel] = ctrl.middle_position - ctrl.middle_tolerance - 1'b1;
		send_frame(ctrl.start_marker, ch, 8'h00, ctrl.end_marker);
		ch[ctrl.mode_channel] = ctrl.middle_position + ctrl.middle_tolerance + 1'b1;
		send_frame(ctrl.start_marker, ch, 8'hFF, ctrl.end_marker);
		settle();
	endtask

	task automatic test_frame_rejects();
		analog_t ch;

		random_analog(ch);
		send_frame(ctrl.start_marker ^ 8'h01, ch, 8'h00, ctrl.end_marker);
		send_frame(ctrl.start_marker, ch, 8'h00, ctrl.end_marker ^ 8'h80);
		send_frame(~ctrl.start_marker, ch, 8'h08, ~ctrl.end_marker);
		send_frame(ctrl.start_marker, ch, 8'h08, ctrl.end_marker);
		settle();
	endtask

	task automatic test_register_extremes();
		analog_t ch;
		int      idx;

		// upper data bits are dropped by the narrower registers
		write_reg(CFG_START_MARKER, 11'h7FF);
		write_reg(CFG_END_MARKER, 11'h7FF);
		write_reg(CFG_MODE_CHANNEL, 11'h7F1);
		write_reg(CFG_MIDDLE_POSITION, '0);
		write_reg(CFG_MIDDLE_TOLERANCE, 11'h7FF);
		for (idx = int'(CFG_MIDDLE_TOLERANCE) + 1; idx < 2**CFG_IDX_W; idx++)
			write_reg(CFG_IDX_W'(idx), '0);
		random_analog(ch);
		send_frame(ctrl.start_marker, ch, 8'h02, ctrl.end_marker);
		settle();

		write_reg(CFG_MODE_CHANNEL, 11'h7F2);
		write_reg(CFG_MIDDLE_TOLERANCE, '0);
		send_frame(ctrl.start_marker, ch, 8'h00, ctrl.end_marker);
		settle();

		write_reg(CFG_MODE_CHANNEL, 11'h01F);
		write_reg(CFG_MIDDLE_POSITION, 11'h7FF);
		send_frame(ctrl.start_marker, ch, 8'h00, ctrl.end_marker);
		settle();

		write_reg(CFG_START_MARKER, 11'h700);
		write_reg(CFG_END_MARKER, '0);
		write_reg(CFG_MODE_CHANNEL, '0);
		write_reg(CFG_MIDDLE_TOLERANCE, 11'h7FF);
		ch[0] = DIGITAL_ON;
		send_frame(ctrl.start_marker, ch, 8'h00, ctrl.end_marker);
		ch[0] = '0;
		send_frame(ctrl.start_marker, ch, 8'h00, ctrl.end_marker);
		send_frame(RST_START_MARKER, ch, 8'h00, ctrl.end_marker);
		settle();
	endtask

	task automatic test_output_backpressure();
		analog_t ch;
		int      k;

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		stall_asks++;
		for (k = 0; k < 2; k++) begin
			random_analog(ch);
			send_frame(ctrl.start_marker, ch, 8'($urandom_range(255)), ctrl.end_marker);
		end
		settle();
	endtask

	task automatic random_setting();
		logic [4:0] sel;

		sel = ($urandom_range(99) < 85) ? 5'($urandom_range(NUM_CHANNELS - 1))
			: 5'($urandom_range(31, NUM_CHANNELS));
		write_reg(CFG_START_MARKER, CFG_DATA_W'($urandom_range(2047)));
		write_reg(CFG_END_MARKER, CFG_DATA_W'($urandom_range(2047)));
		write_reg(CFG_MODE_CHANNEL, {6'($urandom_range(63)), sel});
		write_reg(CFG_MIDDLE_POSITION, CFG_DATA_W'($urandom_range(CH_MAX)));
		write_reg(CFG_MIDDLE_TOLERANCE, ($urandom_range(3) == 0)
			? CFG_DATA_W'($urandom_range(CH_MAX)) : CFG_DATA_W'($urandom_range(200)));
	endtask

	task automatic random_draw();
		analog_t    ch;
		logic [7:0] first;
		logic [7:0] closing;
		logic [7:0] flags;
		int         roll;
		int         v;

		roll = $urandom_range(99);
		if (roll >= 85) begin
			repeat ($urandom_range(30, 1)) send_byte(8'($urandom_range(255)));
			return;
		end
		realign();
		random_analog(ch);
		if (ctrl.mode_channel < NUM_ANALOG && $urandom_range(2) == 0) begin
			case ($urandom_range(3))
				0: v = int'(ctrl.middle_position) - int'(ctrl.middle_tolerance) - 1;
				1: v = int'(ctrl.middle_position) - int'(ctrl.middle_tolerance);
				2: v = int'(ctrl.middle_position) + int'(ctrl.middle_tolerance);
				default: v = int'(ctrl.middle_position) + int'(ctrl.middle_tolerance) + 1;
			endcase
			if (v >= 0 && v <= CH_MAX)
				ch[ctrl.mode_channel] = CH_W'(v);
		end
		flags = 8'($urandom_range(255));
		if ($urandom_range(3) != 0)
			flags[FLAG_FS] = 1'b0;
		first   = ctrl.start_marker;
		closing = ctrl.end_marker;
		if (roll >= 70) begin
			if ($urandom_range(1) == 0)
				first = first ^ 8'($urandom_range(255, 1));
			else
				closing = closing ^ 8'($urandom_range(255, 1));
		end
		send_frame(first, ch, flags, closing);
	endtask

	task automatic test_random_traffic();
		int phase;

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 29;
					sink_idle_pct = 54;
				end
				1: begin
					src_idle_pct  = 54;
					sink_idle_pct = 29;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			random_setting();
			random_draw();
			settle();
		end
	endtask

	initial begin
		rx_ch.valid   = 1'b0;
		rx_ch.payload = '0;
		res_ch.ready  = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_setup();
		test_frame_rejects();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic();
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/sbf_pkg.sv
src/sbf_stream_if.sv
src/sbf_store.sv
src/sbf_collect.sv
src/sbf_unpack.sv
src/sbus_frame_decoder_core.sv
bench/testbench.sv
